### src/utf8c_pkg.sv
// shared types, constants and the upper-half code point table
package utf8c_pkg;

  localparam int unsigned MapEntriesDefault = 64;
  localparam int unsigned StdEntries        = 64;

  localparam logic [2:0] SeqNone   = 3'd7;
  localparam logic [7:0] Backslash = 8'h5C;

  localparam logic [15:0] StdMap [0:StdEntries-1] = '{
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h0098, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
  };

  // register indexes of the configuration port
  localparam logic CfgInputLimit  = 1'b0;
  localparam logic CfgOutputLimit = 1'b1;

  typedef struct packed {
    logic load;
    logic decode;
    logic lookup;
    logic push_bs;
    logic push_term;
    logic push_main;
  } utf8c_cmd_t;

  typedef struct packed {
    logic bs;
    logic term;
    logic need_lookup;
    logic main;
    logic slot_free;
  } utf8c_status_t;

  function automatic logic [15:0] map_entry(input int unsigned idx);
    logic [15:0] val;
    if (idx < StdEntries) begin
      val = StdMap[idx[5:0]];
    end else begin
      val = 16'h0080;
    end
    return val;
  endfunction

endpackage

### src/utf8_to_cp1251_converter_unit.sv
// top level of the utf-8 to windows-1251 converter
//
// the slave stream takes one raw utf-8 byte per transaction in s_axis_tdata.
// the master stream gives converted bytes: tdata holds the byte and the running
// output length, tlast marks the terminator that closes a string (zero byte,
// final length). a zero input byte or a reached limit closes the string; after
// a limit stop input is discarded up to the next zero byte.
// the cfg channel writes input_limit (index 0) and output_limit (index 1);
// it is always ready and should be used only while the converter is idle.
// one byte is handled at a time by the controller: load, decode and route,
// then idle for a byte with no result; a byte that gives one result directly
// (plain ascii, a passed-on backslash, a terminator) takes its push state, the
// byte that completes a code point first takes the lookup state for the
// upper-half table compare (with or without a match), and a held backslash is
// pushed before a terminator; a result leaves via a single output register.
// while the receiver stalls, the controller waits in its push state and the
// slave side stays not ready; the output register holds its transaction.
// synchronous reset restores both limits to 65535 and clears all string state.
module utf8_to_cp1251_converter_unit
  import utf8c_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = MapEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] out_length
  output logic        m_axis_tlast,   // is_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  utf8c_cmd_t    cmd;
  utf8c_status_t status;
  logic [7:0]    out_byte;
  logic [15:0]   out_length;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {out_length, out_byte};

  utf8c_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  utf8c_datapath #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (s_axis_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (out_byte),
    .out_last   (m_axis_tlast),
    .out_length (out_length)
  );

endmodule

### src/utf8c_ctrl.sv
// controller state machine sequencing decode, lookup and result pushes
module utf8c_ctrl
  import utf8c_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  utf8c_status_t status,
  output utf8c_cmd_t    cmd
);

  typedef enum logic [6:0] {
    IDLE      = 7'b0000001,
    DECODE    = 7'b0000010,
    ROUTE     = 7'b0000100,
    PUSH_BS   = 7'b0001000,
    PUSH_TERM = 7'b0010000,
    LOOKUP    = 7'b0100000,
    PUSH_MAIN = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        cmd.decode = 1'b1;
        state_next = ROUTE;
      end
      ROUTE: begin
        if (status.bs) begin
          state_next = PUSH_BS;
        end else if (status.term) begin
          state_next = PUSH_TERM;
        end else if (status.need_lookup) begin
          state_next = LOOKUP;
        end else if (status.main) begin
          state_next = PUSH_MAIN;
        end else begin
          state_next = IDLE;
        end
      end
      PUSH_BS: begin
        if (status.slot_free) begin
          cmd.push_bs = 1'b1;
          state_next  = status.term ? PUSH_TERM : IDLE;
        end
      end
      PUSH_TERM: begin
        if (status.slot_free) begin
          cmd.push_term = 1'b1;
          state_next    = IDLE;
        end
      end
      LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = PUSH_MAIN;
      end
      PUSH_MAIN: begin
        if (!status.main) begin
          state_next = IDLE;
        end else if (status.slot_free) begin
          cmd.push_main = 1'b1;
          state_next    = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

### src/utf8c_datapath.sv
// datapath: sequence decoder, string counters, code point lookup, output register
module utf8c_datapath
  import utf8c_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = MapEntriesDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  input  utf8c_cmd_t    cmd,
  output utf8c_status_t status,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic [15:0]   out_length
);

  logic [15:0] input_limit;
  logic [15:0] output_limit;
  logic [7:0]  byte_reg;
  logic [2:0]  bytes_expected;
  logic [1:0]  bytes_seen;
  logic [20:0] code_accum;
  logic        backslash_pending;
  logic [15:0] in_count;
  logic [15:0] out_count;
  logic        draining;
  logic        bs_flag;
  logic        term_flag;
  logic        lookup_flag;
  logic        main_flag;
  logic [7:0]  main_byte;
  logic [20:0] cp_reg;

  logic        bs_emit;
  logic [15:0] oc_eff;
  logic        stop;
  logic [20:0] accum_shift;
  logic [1:0]  seen_inc;
  logic        map_hit;
  logic [7:0]  map_byte;
  logic        lk_valid;
  logic [7:0]  lk_byte;

  assign bs_emit     = backslash_pending && (byte_reg == Backslash);
  assign oc_eff      = out_count + 16'(bs_emit);
  assign stop        = (byte_reg == 8'h00) || (oc_eff >= output_limit)
                    || (in_count >= input_limit);
  assign accum_shift = {code_accum[14:0], byte_reg[5:0]};
  assign seen_inc    = bytes_seen + 2'd1;

  always_comb begin
    map_hit  = 1'b0;
    map_byte = 8'h00;
    for (int i = int'(MAP_ENTRIES) - 1; i >= 0; i--) begin
      if (cp_reg == {5'b0, map_entry(i)}) begin
        map_hit  = 1'b1;
        map_byte = 8'(8'h80 + i);
      end
    end
  end

  always_comb begin
    if (cp_reg >= 21'h80 && cp_reg <= 21'hFF) begin
      lk_valid = 1'b1;
      lk_byte  = cp_reg[7:0];
    end else if (cp_reg >= 21'h0410 && cp_reg <= 21'h044F) begin
      lk_valid = 1'b1;
      lk_byte  = 8'(cp_reg[7:0] - 8'h10 + 8'hC0);
    end else begin
      lk_valid = map_hit;
      lk_byte  = map_byte;
    end
  end

  assign status.bs          = bs_flag;
  assign status.term        = term_flag;
  assign status.need_lookup = lookup_flag;
  assign status.main        = main_flag;
  assign status.slot_free   = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_limit  <= 16'hFFFF;
      output_limit <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgInputLimit:  input_limit  <= cfg_data;
        CfgOutputLimit: output_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_reg <= in_byte;
    end
    if (cmd.decode) begin
      cp_reg <= accum_shift;
    end
    if (cmd.decode && !draining && !stop && bytes_expected == SeqNone) begin
      main_byte <= byte_reg;
    end else if (cmd.lookup) begin
      main_byte <= lk_byte;
    end
  end

  // decoder and string state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected    <= SeqNone;
      bytes_seen        <= 2'd0;
      code_accum        <= '0;
      backslash_pending <= 1'b0;
      in_count          <= '0;
      draining          <= 1'b0;
      bs_flag           <= 1'b0;
      term_flag         <= 1'b0;
      lookup_flag       <= 1'b0;
      main_flag         <= 1'b0;
    end else if (cmd.decode) begin
      bs_flag     <= 1'b0;
      term_flag   <= 1'b0;
      lookup_flag <= 1'b0;
      main_flag   <= 1'b0;
      if (draining) begin
        if (byte_reg == 8'h00) begin
          draining <= 1'b0;
        end
      end else begin
        bs_flag           <= bs_emit;
        backslash_pending <= 1'b0;
        if (stop) begin
          term_flag      <= 1'b1;
          draining       <= (byte_reg != 8'h00);
          bytes_expected <= SeqNone;
          bytes_seen     <= 2'd0;
          code_accum     <= '0;
          in_count       <= '0;
        end else begin
          in_count <= in_count + 16'd1;
          if (bytes_expected == SeqNone) begin
            if (byte_reg >= 8'hF8) begin
              bytes_expected <= SeqNone;
            end else if (byte_reg >= 8'hF0) begin
              code_accum     <= {18'b0, byte_reg[2:0]};
              bytes_expected <= 3'd3;
              bytes_seen     <= 2'd0;
            end else if (byte_reg >= 8'hE0) begin
              code_accum     <= {17'b0, byte_reg[3:0]};
              bytes_expected <= 3'd2;
              bytes_seen     <= 2'd0;
            end else if (byte_reg >= 8'hC0) begin
              code_accum     <= {16'b0, byte_reg[4:0]};
              bytes_expected <= 3'd1;
              bytes_seen     <= 2'd0;
            end else if (byte_reg <= 8'h7F) begin
              if (byte_reg == Backslash) begin
                backslash_pending <= 1'b1;
              end else begin
                main_flag <= 1'b1;
              end
            end
          end else if (byte_reg > 8'hBF) begin
            bytes_expected <= SeqNone;
            bytes_seen     <= 2'd0;
          end else begin
            code_accum <= accum_shift;
            if ({1'b0, seen_inc} == bytes_expected) begin
              bytes_expected <= SeqNone;
              bytes_seen     <= 2'd0;
              lookup_flag    <= 1'b1;
            end else begin
              bytes_seen <= seen_inc;
            end
          end
        end
      end
    end else if (cmd.lookup) begin
      lookup_flag <= 1'b0;
      main_flag   <= lk_valid;
    end
  end

  // output register and emitted byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_count <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.push_bs || cmd.push_main) begin
        out_valid  <= 1'b1;
        out_byte   <= cmd.push_bs ? Backslash : main_byte;
        out_last   <= 1'b0;
        out_length <= out_count + 16'd1;
        out_count  <= out_count + 16'd1;
      end else if (cmd.push_term) begin
        out_valid  <= 1'b1;
        out_byte   <= 8'h00;
        out_last   <= 1'b1;
        out_length <= out_count;
        out_count  <= '0;
      end
    end
  end

endmodule
